// ===== src/imu_remap_and_accel_lowpass_assert.svh =====
// assertion macros for the imu remap and accel low-pass block
// used by the port checker; no other dependencies
`ifndef IMU_REMAP_AND_ACCEL_LOWPASS_ASSERT_SVH
`define IMU_REMAP_AND_ACCEL_LOWPASS_ASSERT_SVH

// cond must hold in the cycle after trig, outside reset
`define IMURL_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

// cond must hold in the cycle after a reset cycle
`define IMURL_ASSERT_AFTER_RST(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cond)) else $error(msg);

`endif

// ===== src/imurl_pkg.sv =====
// shared types, constants and helpers for the imu remap and accel low-pass block
// no dependencies
`default_nettype none

package imurl_pkg;

  localparam int AXES    = 3;
  localparam int FRAC    = 12;
  localparam int Q_W     = 16 + FRAC;
  localparam int PROD_W  = 60;
  localparam int ACC_W   = 62;
  localparam int SHIFT   = 30;
  localparam int IDX_W   = 3;

  typedef logic signed [15:0]      s16_t;
  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Q2.30 filter coefficients
  localparam logic signed [31:0] COEF_A1 = 32'sd2071735500;
  localparam logic signed [31:0] COEF_A2 = -32'sd1000494913;
  localparam logic signed [31:0] COEF_B0 = 32'sd2501237;

  localparam acc_t ROUND_HALF = acc_t'(1) <<< (SHIFT - 1);
  localparam logic signed [31:0] STATE_MAX = 32'sd134217727;
  localparam logic signed [31:0] STATE_MIN = -32'sd134217728;

  typedef enum logic [IDX_W-1:0] {
    REG_GYRO_OFF_X  = 3'd0,
    REG_GYRO_OFF_Y  = 3'd1,
    REG_GYRO_OFF_Z  = 3'd2,
    REG_ACCEL_OFF_X = 3'd3,
    REG_ACCEL_OFF_Y = 3'd4,
    REG_ACCEL_OFF_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic primed;
  } lane_ctl_t;

  function automatic s16_t sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/imurl_if.sv =====
// valid/ready channel interfaces for raw samples and conditioned results
// depends on imurl_pkg
`default_nettype none

interface imurl_raw_if;
  logic valid;
  logic ready;
  imurl_pkg::s16_t raw_gyro_x;
  imurl_pkg::s16_t raw_gyro_y;
  imurl_pkg::s16_t raw_gyro_z;
  imurl_pkg::s16_t raw_accel_x;
  imurl_pkg::s16_t raw_accel_y;
  imurl_pkg::s16_t raw_accel_z;

  modport source (output valid, raw_gyro_x, raw_gyro_y, raw_gyro_z,
                  raw_accel_x, raw_accel_y, raw_accel_z, input ready);
  modport sink (input valid, raw_gyro_x, raw_gyro_y, raw_gyro_z,
                raw_accel_x, raw_accel_y, raw_accel_z, output ready);
endinterface

interface imurl_body_if;
  logic valid;
  logic ready;
  imurl_pkg::s16_t body_gyro_x;
  imurl_pkg::s16_t body_gyro_y;
  imurl_pkg::s16_t body_gyro_z;
  imurl_pkg::s16_t smooth_accel_x;
  imurl_pkg::s16_t smooth_accel_y;
  imurl_pkg::s16_t smooth_accel_z;

  modport source (output valid, body_gyro_x, body_gyro_y, body_gyro_z,
                  smooth_accel_x, smooth_accel_y, smooth_accel_z, input ready);
  modport sink (input valid, body_gyro_x, body_gyro_y, body_gyro_z,
                smooth_accel_x, smooth_accel_y, smooth_accel_z, output ready);
endinterface

`default_nettype wire

// ===== src/imu_remap_and_accel_lowpass.sv =====
// path: calibrated input register, lane products, result register
// the filter recursion loads a new sample only after the last one has committed
//   (product register, then accumulate and saturate into the lane state)
// a new input beat is taken while a result waits on the output
// reset (synchronous, active high) clears offsets, filter priming and all valids
// top level: calibration stage, three filter lanes, output register; uses imurl_pkg, imurl_if
`default_nettype none

module imu_remap_and_accel_lowpass (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [imurl_pkg::IDX_W-1:0]       wr_index,
  input  imurl_pkg::s16_t                   wr_data,
  imurl_raw_if.sink                         in_ch,
  imurl_body_if.source                      out_ch
);
  import imurl_pkg::*;

  s16_t gyro_off  [AXES];
  s16_t accel_off [AXES];

  logic s1_valid;
  s16_t s1_gyro  [AXES];
  s16_t s1_accel [AXES];

  logic busy;
  s16_t b_gyro [AXES];

  logic out_valid;
  s16_t out_gyro  [AXES];
  s16_t out_accel [AXES];

  logic primed;

  s16_t cal_gyro  [AXES];
  s16_t cal_accel [AXES];
  s16_t lane_y    [AXES];

  logic      in_accept;
  logic      out_free;
  lane_ctl_t ctl;

  assign in_ch.ready = !s1_valid || !busy;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign ctl.load    = s1_valid && !busy;
  assign ctl.commit  = busy && out_free;
  assign ctl.primed  = primed;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        gyro_off[i]  <= '0;
        accel_off[i] <= '0;
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_GYRO_OFF_X:  gyro_off[0]  <= wr_data;
        REG_GYRO_OFF_Y:  gyro_off[1]  <= wr_data;
        REG_GYRO_OFF_Z:  gyro_off[2]  <= wr_data;
        REG_ACCEL_OFF_X: accel_off[0] <= wr_data;
        REG_ACCEL_OFF_Y: accel_off[1] <= wr_data;
        REG_ACCEL_OFF_Z: accel_off[2] <= wr_data;
        default: ;
      endcase
    end
  end

  imurl_cal u_cal_gyro (
    .raw_x (in_ch.raw_gyro_x),
    .raw_y (in_ch.raw_gyro_y),
    .raw_z (in_ch.raw_gyro_z),
    .off_x (gyro_off[0]),
    .off_y (gyro_off[1]),
    .off_z (gyro_off[2]),
    .cal_x (cal_gyro[0]),
    .cal_y (cal_gyro[1]),
    .cal_z (cal_gyro[2])
  );

  imurl_cal u_cal_accel (
    .raw_x (in_ch.raw_accel_x),
    .raw_y (in_ch.raw_accel_y),
    .raw_z (in_ch.raw_accel_z),
    .off_x (accel_off[0]),
    .off_y (accel_off[1]),
    .off_z (accel_off[2]),
    .cal_x (cal_accel[0]),
    .cal_y (cal_accel[1]),
    .cal_z (cal_accel[2])
  );

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    imurl_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .cal   (s1_accel[g]),
      .y_int (lane_y[g])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
      primed    <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (ctl.load) begin
        s1_valid <= 1'b0;
      end
      if (ctl.load) begin
        busy <= 1'b1;
      end else if (ctl.commit) begin
        busy <= 1'b0;
      end
      if (ctl.commit) begin
        out_valid <= 1'b1;
        primed    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      if (in_accept) begin
        s1_gyro[i]  <= cal_gyro[i];
        s1_accel[i] <= cal_accel[i];
      end
      if (ctl.load) begin
        b_gyro[i] <= s1_gyro[i];
      end
      if (ctl.commit) begin
        out_gyro[i]  <= b_gyro[i];
        out_accel[i] <= lane_y[i];
      end
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.body_gyro_x    = out_gyro[0];
  assign out_ch.body_gyro_y    = out_gyro[1];
  assign out_ch.body_gyro_z    = out_gyro[2];
  assign out_ch.smooth_accel_x = out_accel[0];
  assign out_ch.smooth_accel_y = out_accel[1];
  assign out_ch.smooth_accel_z = out_accel[2];

endmodule

`default_nettype wire

// ===== src/imurl_cal.sv =====
// board remap and saturating offset add for one three-axis vector
// depends on imurl_pkg
`default_nettype none

module imurl_cal (
  input  imurl_pkg::s16_t raw_x,
  input  imurl_pkg::s16_t raw_y,
  input  imurl_pkg::s16_t raw_z,
  input  imurl_pkg::s16_t off_x,
  input  imurl_pkg::s16_t off_y,
  input  imurl_pkg::s16_t off_z,
  output imurl_pkg::s16_t cal_x,
  output imurl_pkg::s16_t cal_y,
  output imurl_pkg::s16_t cal_z
);
  import imurl_pkg::*;

  logic signed [17:0] sum_x;
  logic signed [17:0] sum_y;
  logic signed [17:0] sum_z;

  // x' = y, y' = -x, z' = z
  assign sum_x = 18'(raw_y) + 18'(off_x);
  assign sum_y = 18'(off_y) - 18'(raw_x);
  assign sum_z = 18'(raw_z) + 18'(off_z);

  assign cal_x = sat16(sum_x);
  assign cal_y = sat16(sum_y);
  assign cal_z = sat16(sum_z);

endmodule

`default_nettype wire

// ===== src/imurl_lane.sv =====
// one axis of the second-order low-pass: product stage, then accumulate and state update
// depends on imurl_pkg
`default_nettype none

module imurl_lane (
  input  logic                  clk,
  input  imurl_pkg::lane_ctl_t  ctl,
  input  imurl_pkg::s16_t       cal,
  output imurl_pkg::s16_t       y_int
);
  import imurl_pkg::*;

  q_t    prev;
  q_t    older;
  q_t    tap1;
  prod_t p_a1;
  prod_t p_a2;
  prod_t p_b0;

  q_t    x_q;
  q_t    y1_sel;
  q_t    y2_sel;
  prod_t m_a1;
  prod_t m_a2;
  prod_t m_b0;
  acc_t  acc;
  logic signed [31:0] rnd;
  q_t    y_next;

  // first sample primes both taps
  assign x_q    = $signed({cal, {FRAC{1'b0}}});
  assign y1_sel = ctl.primed ? prev  : x_q;
  assign y2_sel = ctl.primed ? older : x_q;

  assign m_a1 = COEF_A1 * y1_sel;
  assign m_a2 = COEF_A2 * y2_sel;
  assign m_b0 = COEF_B0 * x_q;

  assign acc = acc_t'(p_a1) + acc_t'(p_a2) + acc_t'(p_b0) + ROUND_HALF;
  assign rnd = 32'(acc >>> SHIFT);

  always_comb begin
    if (rnd > STATE_MAX) begin
      y_next = STATE_MAX[Q_W-1:0];
    end else if (rnd < STATE_MIN) begin
      y_next = STATE_MIN[Q_W-1:0];
    end else begin
      y_next = rnd[Q_W-1:0];
    end
  end

  assign y_int = y_next[Q_W-1:FRAC];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      p_a1 <= m_a1;
      p_a2 <= m_a2;
      p_b0 <= m_b0;
      tap1 <= y1_sel;
    end
    if (ctl.commit) begin
      older <= tap1;
      prev  <= y_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/imurl_checker.sv =====
// port-level checks for the imu remap and accel low-pass block, bound to the top level
// depends on imurl_pkg and imu_remap_and_accel_lowpass_assert.svh
`default_nettype none

`include "imu_remap_and_accel_lowpass_assert.svh"

module imurl_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input imurl_pkg::s16_t body_gyro_x,
  input imurl_pkg::s16_t smooth_accel_x,
  input imurl_pkg::s16_t smooth_accel_z
);

  `IMURL_ASSERT_AFTER_RST(a_rst_empty, !out_valid && in_ready, "not empty after reset")
  `IMURL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `IMURL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(body_gyro_x) && $stable(smooth_accel_x) && $stable(smooth_accel_z), "stalled result changed")
  `IMURL_ASSERT_NEXT(a_ready_back, !in_ready && out_ready, in_ready, "input stalled with output free")

endmodule

bind imu_remap_and_accel_lowpass imurl_checker u_imurl_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .body_gyro_x    (out_ch.body_gyro_x),
  .smooth_accel_x (out_ch.smooth_accel_x),
  .smooth_accel_z (out_ch.smooth_accel_z)
);

`default_nettype wire

// ===== tb/sv/imu_remap_and_accel_lowpass_test.sv =====
// self-checking test of imu_remap_and_accel_lowpass: board remap, offsets, accel low-pass
// an in-line predictor checks every result beat under random idling, stalls and a long hold
// depends on imurl_pkg, imurl_if and the block itself
`timescale 1ns / 100ps

module imu_remap_and_accel_lowpass_test;
  import imurl_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 400;

  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  localparam reg_idx_t GYRO_REG[3]  = '{REG_GYRO_OFF_X, REG_GYRO_OFF_Y, REG_GYRO_OFF_Z};
  localparam reg_idx_t ACCEL_REG[3] = '{REG_ACCEL_OFF_X, REG_ACCEL_OFF_Y, REG_ACCEL_OFF_Z};

  localparam longint Q30_A1   = 64'sd2071735500;
  localparam longint Q30_A2   = -64'sd1000494913;
  localparam longint Q30_B0   = 64'sd2501237;
  localparam longint Q30_HALF = 64'sd536870912;
  localparam longint Q12_MAX  = 64'sd134217727;
  localparam longint Q12_MIN  = -64'sd134217728;

  localparam s16_t S16_MAX = 16'sh7fff;
  localparam s16_t S16_MIN = 16'sh8000;

  typedef struct packed {
    s16_t gyro_x;
    s16_t gyro_y;
    s16_t gyro_z;
    s16_t accel_x;
    s16_t accel_y;
    s16_t accel_z;
  } raw_sample_t;

  typedef struct packed {
    s16_t gyro_x;
    s16_t gyro_y;
    s16_t gyro_z;
    s16_t accel_x;
    s16_t accel_y;
    s16_t accel_z;
  } body_sample_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_index;
  s16_t              wr_data;

  imurl_raw_if  raw_ch();
  imurl_body_if body_ch();

  imu_remap_and_accel_lowpass dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_ch    (raw_ch),
    .out_ch   (body_ch)
  );

  s16_t         gyro_trim[3];
  s16_t         accel_trim[3];
  int           accel_y1[3];
  int           accel_y2[3];
  bit           filter_primed;
  body_sample_t expected_body[$];
  int           mismatches;
  int           idle_odds;
  int           hold_asks;
  int           hold_taken;
  int           hold_left;
  int           stall_left;
  int           cycles;
  bit           spare_pick;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("imu_remap_and_accel_lowpass_test: done, errors");
      $finish;
    end
  end

  // predictor
  function automatic s16_t clip16(input int v);
    if (v > 32767) begin
      return S16_MAX;
    end else if (v < -32768) begin
      return S16_MIN;
    end
    return s16_t'(v);
  endfunction

  function automatic int lowpass_q12(input int y1, input int y2, input int x);
    longint acc;
    acc = Q30_A1 * longint'(y1) + Q30_A2 * longint'(y2) + Q30_B0 * (longint'(x) <<< 12);
    acc = (acc + Q30_HALF) >>> 30;
    if (acc > Q12_MAX) begin
      return int'(Q12_MAX);
    end else if (acc < Q12_MIN) begin
      return int'(Q12_MIN);
    end
    return int'(acc);
  endfunction

  function automatic body_sample_t condition_sample(input raw_sample_t s);
    int           rot_g[3];
    int           rot_a[3];
    int           cal[3];
    int           y;
    s16_t         smooth[3];
    body_sample_t b;
    rot_g[0] = int'($signed(s.gyro_y));
    rot_g[1] = -int'($signed(s.gyro_x));
    rot_g[2] = int'($signed(s.gyro_z));
    rot_a[0] = int'($signed(s.accel_y));
    rot_a[1] = -int'($signed(s.accel_x));
    rot_a[2] = int'($signed(s.accel_z));
    for (int i = 0; i < 3; i++) begin
      cal[i] = int'(clip16(rot_a[i] + int'(accel_trim[i])));
    end
    if (!filter_primed) begin
      for (int i = 0; i < 3; i++) begin
        accel_y1[i] = cal[i] * 4096;
        accel_y2[i] = cal[i] * 4096;
      end
      filter_primed = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      y = lowpass_q12(accel_y1[i], accel_y2[i], cal[i]);
      accel_y2[i] = accel_y1[i];
      accel_y1[i] = y;
      smooth[i] = s16_t'(y >>> 12);
    end
    b.gyro_x  = clip16(rot_g[0] + int'(gyro_trim[0]));
    b.gyro_y  = clip16(rot_g[1] + int'(gyro_trim[1]));
    b.gyro_z  = clip16(rot_g[2] + int'(gyro_trim[2]));
    b.accel_x = smooth[0];
    b.accel_y = smooth[1];
    b.accel_z = smooth[2];
    return b;
  endfunction

  function automatic void check_field(input string name, input s16_t want, input s16_t got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    body_sample_t want;
    if (!rst && body_ch.valid && body_ch.ready) begin
      if (expected_body.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = expected_body.pop_front();
        check_field("body_gyro_x", want.gyro_x, body_ch.body_gyro_x);
        check_field("body_gyro_y", want.gyro_y, body_ch.body_gyro_y);
        check_field("body_gyro_z", want.gyro_z, body_ch.body_gyro_z);
        check_field("smooth_accel_x", want.accel_x, body_ch.smooth_accel_x);
        check_field("smooth_accel_y", want.accel_y, body_ch.smooth_accel_y);
        check_field("smooth_accel_z", want.accel_z, body_ch.smooth_accel_z);
      end
    end
  end

  // result ready: random stalls plus the long hold
  always @(posedge clk) begin
    if (rst) begin
      body_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      body_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asks) begin
      body_ch.ready <= 1'b0;
      hold_taken <= hold_asks;
      hold_left <= HOLD_CYCLES - 1;
    end else if (stall_left > 0) begin
      body_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
      body_ch.ready <= 1'b0;
      stall_left <= $urandom_range(13);
    end else begin
      body_ch.ready <= 1'b1;
    end
  end

  function automatic s16_t rand16();
    case ($urandom_range(7))
      0: return S16_MIN;
      1: return S16_MAX;
      default: return s16_t'($urandom_range(65535));
    endcase
  endfunction

  function automatic raw_sample_t random_sample();
    raw_sample_t s;
    s.gyro_x  = rand16();
    s.gyro_y  = rand16();
    s.gyro_z  = rand16();
    s.accel_x = rand16();
    s.accel_y = rand16();
    s.accel_z = rand16();
    return s;
  endfunction

  function automatic raw_sample_t uniform_sample(input s16_t v);
    raw_sample_t s;
    s.gyro_x  = v;
    s.gyro_y  = v;
    s.gyro_z  = v;
    s.accel_x = v;
    s.accel_y = v;
    s.accel_z = v;
    return s;
  endfunction

  task automatic send_sample(input raw_sample_t s);
    if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
      raw_ch.valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    raw_ch.valid       <= 1'b1;
    raw_ch.raw_gyro_x  <= s.gyro_x;
    raw_ch.raw_gyro_y  <= s.gyro_y;
    raw_ch.raw_gyro_z  <= s.gyro_z;
    raw_ch.raw_accel_x <= s.accel_x;
    raw_ch.raw_accel_y <= s.accel_y;
    raw_ch.raw_accel_z <= s.accel_z;
    do @(posedge clk); while (!raw_ch.ready);
    expected_body.push_back(condition_sample(s));
  endtask

  task automatic settle();
    raw_ch.valid <= 1'b0;
    while (expected_body.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // all six offsets, then an out-of-range index that must change nothing
  task automatic program_trims(input s16_t g[3], input s16_t a[3]);
    for (int i = 0; i < 3; i++) begin
      wr_en    <= 1'b1;
      wr_index <= GYRO_REG[i];
      wr_data  <= g[i];
      @(posedge clk);
      gyro_trim[i] = g[i];
    end
    for (int i = 0; i < 3; i++) begin
      wr_index <= ACCEL_REG[i];
      wr_data  <= a[i];
      @(posedge clk);
      accel_trim[i] = a[i];
    end
    wr_index <= spare_pick ? IDX_SPARE_HI : IDX_SPARE_LO;
    wr_data  <= s16_t'($urandom_range(65535));
    spare_pick = ~spare_pick;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_uniform_trims(input s16_t v);
    s16_t g[3];
    s16_t a[3];
    for (int i = 0; i < 3; i++) begin
      g[i] = v;
      a[i] = v;
    end
    program_trims(g, a);
  endtask

  task automatic program_random_trims(input bit extreme);
    s16_t g[3];
    s16_t a[3];
    for (int i = 0; i < 3; i++) begin
      if (extreme) begin
        g[i] = $urandom_range(1) ? S16_MAX : S16_MIN;
        a[i] = $urandom_range(1) ? S16_MAX : S16_MIN;
      end else begin
        g[i] = rand16();
        a[i] = rand16();
      end
    end
    program_trims(g, a);
  endtask

  // accel held at random levels with jitter, broken up by noise beats
  task automatic run_accel_steps(input int n_items);
    raw_sample_t s;
    s16_t        level[3];
    int          run;
    int          amp;
    int          k;
    k = 0;
    while (k < n_items) begin
      for (int i = 0; i < 3; i++) begin
        level[i] = rand16();
      end
      run = ($urandom_range(3) == 0) ? $urandom_range(160, 60) : $urandom_range(20, 1);
      amp = ($urandom_range(1) == 0) ? 0 : $urandom_range(300);
      for (int j = 0; j < run && k < n_items; j++) begin
        s = random_sample();
        if ($urandom_range(15) != 0) begin
          s.accel_x = clip16(int'(level[0]) + int'($urandom_range(2 * amp)) - amp);
          s.accel_y = clip16(int'(level[1]) + int'($urandom_range(2 * amp)) - amp);
          s.accel_z = clip16(int'(level[2]) + int'($urandom_range(2 * amp)) - amp);
        end
        send_sample(s);
        k++;
      end
    end
  endtask

  task automatic test_priming();
    s16_t        g[3];
    s16_t        a[3];
    raw_sample_t s;
    g[0] = 16'sd100;
    g[1] = -16'sd200;
    g[2] = 16'sd300;
    a[0] = -16'sd5;
    a[1] = 16'sd7;
    a[2] = -16'sd9;
    program_trims(g, a);
    s.gyro_x  = S16_MIN;
    s.gyro_y  = S16_MAX;
    s.gyro_z  = S16_MIN;
    s.accel_x = S16_MIN;
    s.accel_y = S16_MAX;
    s.accel_z = S16_MIN;
    repeat (3) send_sample(s);
    send_sample(uniform_sample(16'sd0));
  endtask

  task automatic test_remap_extremes();
    raw_sample_t s;
    settle();
    program_uniform_trims(16'sd0);
    send_sample(uniform_sample(S16_MIN));
    send_sample(uniform_sample(-16'sd1));
    send_sample(uniform_sample(16'sd0));
    send_sample(uniform_sample(16'sd1));
    send_sample(uniform_sample(S16_MAX));
    s.gyro_x  = S16_MAX;
    s.gyro_y  = S16_MIN;
    s.gyro_z  = 16'sd1;
    s.accel_x = -16'sd1;
    s.accel_y = 16'sd0;
    s.accel_z = 16'sh5a5a;
    send_sample(s);
  endtask

  task automatic test_offset_saturation();
    settle();
    program_uniform_trims(S16_MAX);
    send_sample(uniform_sample(S16_MAX));
    send_sample(uniform_sample(S16_MIN));
    send_sample(uniform_sample(16'sd0));
    settle();
    program_uniform_trims(S16_MIN);
    send_sample(uniform_sample(S16_MAX));
    send_sample(uniform_sample(S16_MIN));
    send_sample(uniform_sample(16'sd0));
  endtask

  // full-scale accel step, long enough for the overshoot to hit the state limits
  task automatic test_step_overshoot();
    raw_sample_t s;
    settle();
    program_uniform_trims(16'sd0);
    for (int n = 0; n < 300; n++) begin
      s = random_sample();
      s.accel_x = (n < 150) ? S16_MAX : S16_MIN;
      s.accel_y = (n < 150) ? S16_MIN : S16_MAX;
      s.accel_z = (n < 150) ? S16_MIN : S16_MAX;
      send_sample(s);
    end
  endtask

  task automatic test_random_steps();
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      program_random_trims(phase == 1);
      run_accel_steps(350);
    end
  endtask

  task automatic test_backpressure();
    settle();
    program_random_trims(1'b0);
    hold_asks <= hold_asks + 1;
    run_accel_steps(250);
  endtask

  task automatic test_streaming();
    settle();
    program_uniform_trims(16'sd0);
    idle_odds <= 0;
    run_accel_steps(250);
  endtask

  initial begin
    raw_ch.valid       = 1'b0;
    raw_ch.raw_gyro_x  = '0;
    raw_ch.raw_gyro_y  = '0;
    raw_ch.raw_gyro_z  = '0;
    raw_ch.raw_accel_x = '0;
    raw_ch.raw_accel_y = '0;
    raw_ch.raw_accel_z = '0;
    wr_en              = 1'b0;
    wr_index           = '0;
    wr_data            = '0;
    for (int i = 0; i < 3; i++) begin
      gyro_trim[i]  = '0;
      accel_trim[i] = '0;
      accel_y1[i]   = 0;
      accel_y2[i]   = 0;
    end
    filter_primed = 1'b0;
    idle_odds     = 4;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_priming();
    test_remap_extremes();
    test_offset_saturation();
    test_step_overshoot();
    test_random_steps();
    test_backpressure();
    test_streaming();

    raw_ch.valid <= 1'b0;
    for (int n = 0; n < 5000 && expected_body.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_body.size() != 0) begin
      $error("%0d expected results never arrived", expected_body.size());
    end
    if (mismatches == 0 && expected_body.size() == 0) begin
      $display("imu_remap_and_accel_lowpass_test: done, clean");
    end else begin
      $display("imu_remap_and_accel_lowpass_test: done, errors");
    end
    $finish;
  end

endmodule
